// ----- src/eye_homing_positioner_unit_macros.svh -----
// Assertion macros shared by the positioner RTL.
// Each macro takes a label, a clock, an active-low reset, a trigger and a consequence.
`ifndef EYE_HOMING_POSITIONER_UNIT_MACROS_SVH
`define EYE_HOMING_POSITIONER_UNIT_MACROS_SVH

// Same-cycle implication.
`define EHP_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("ehp same-cycle check failed");

// Next-cycle implication.
`define EHP_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("ehp next-cycle check failed");

`endif

// ----- src/ehp_pkg.sv -----
package ehp_pkg;

  // Field and register widths.
  localparam int CFG_W      = 24;
  localparam int HOLD_W     = 8;
  localparam int PCT_W      = 7;
  localparam int PROD_W     = 31;
  localparam int CFG_IDX_W  = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LEFT_TRAVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HOME_TMO    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SENSE_HOLD  = 2'd2;

  // Register reset values.
  localparam logic [CFG_W-1:0]  LEFT_TRAVEL_RST = 24'd10000;
  localparam logic [CFG_W-1:0]  HOME_TMO_RST    = 24'd100000;
  localparam logic [HOLD_W-1:0] SENSE_HOLD_RST  = 8'd200;

  // Operation codes.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Percent saturation limit.
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // Divide by 100 is a shift by two and a reciprocal multiply by 1/25.
  // For dividends below 2^30, (y * RECIP25) >> RECIP25_SHIFT is exact.
  localparam int               RECIP25_W     = 29;
  localparam logic [RECIP25_W-1:0] RECIP25   = 29'd343597384;
  localparam int               RECIP25_SHIFT = 33;

  // Sequencer phase.
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HOMING = 2'd1,
    PH_MOVING = 2'd2,
    PH_HALTED = 2'd3
  } phase_t;

  // One result item.
  typedef struct packed {
    logic drive_right;
    logic drive_left;
    logic busy;
    logic done;
    logic halted;
  } res_t;

endpackage

// ----- src/eye_homing_positioner_unit.sv -----
// A result is registered and valid in the cycle after its input transaction is accepted.
// One transaction per cycle while the input is not stalled; the sequencer counters update on each.
// The input stalls only while a held result is itself stalled at the output register.
// Reset (synchronous, active low): idle phase, counters cleared, output empty,
// registers back to travel 10000, timeout 100000 and sensor hold 200.
module eye_homing_positioner_unit #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_op,
  input  logic [ehp_pkg::PCT_W-1:0]       in_position_percent,
  input  logic                            in_sensor_level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_drive_right,
  output logic                            out_drive_left,
  output logic                            out_busy_res,
  output logic                            out_done_res,
  output logic                            out_halted,
  input  logic                            cfg_we,
  input  logic [ehp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ehp_pkg::CFG_W-1:0]       cfg_wdata
);
  import ehp_pkg::*;

  logic [CFG_W-1:0]        left_travel_r;
  logic [CFG_W-1:0]        home_tmo_r;
  logic [HOLD_W-1:0]       sense_hold_r;
  logic                    take;
  logic                    start_load;
  logic [COUNT_WIDTH-1:0]  target;
  res_t                    res_c;
  res_t                    res_q;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_travel_r <= LEFT_TRAVEL_RST;
      home_tmo_r    <= HOME_TMO_RST;
      sense_hold_r  <= SENSE_HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_LEFT_TRAVEL: left_travel_r <= cfg_wdata;
        CFG_IDX_HOME_TMO:    home_tmo_r    <= cfg_wdata;
        CFG_IDX_SENSE_HOLD:  sense_hold_r  <= cfg_wdata[HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign take = in_valid && !in_stall;

  ehp_target #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_target (
    .clk    (clk),
    .load   (start_load),
    .pct    (in_position_percent),
    .travel (left_travel_r),
    .target (target)
  );

  ehp_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .op           (in_op),
    .sensor_level (in_sensor_level),
    .target       (target),
    .home_tmo     (home_tmo_r),
    .sense_hold   (sense_hold_r),
    .start_load   (start_load),
    .res          (res_c)
  );

  ehp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .res_in    (res_c),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .res_out   (res_q)
  );

  assign out_drive_right = res_q.drive_right;
  assign out_drive_left  = res_q.drive_left;
  assign out_busy_res    = res_q.busy;
  assign out_done_res    = res_q.done;
  assign out_halted      = res_q.halted;

endmodule

// ----- src/ehp_target.sv -----
// Move target: the saturated percent times travel is registered on start, the divide by
// 100 is applied combinationally to that product, and the quotient is taken when homing finishes.
module ehp_target #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                        clk,
  input  logic                        load,
  input  logic [ehp_pkg::PCT_W-1:0]   pct,
  input  logic [ehp_pkg::CFG_W-1:0]   travel,
  output logic [COUNT_WIDTH-1:0]      target
);
  import ehp_pkg::*;

  logic [PCT_W-1:0]         pct_sat;
  logic [PROD_W-1:0]        prod_r;
  logic [PROD_W-1:0]        prod_nxt;
  logic [RECIP25_W-1:0]     quarter;
  logic [2*RECIP25_W-1:0]   recip_prod;
  logic [31:0]              quot;

  // Saturate the percent and form the product.
  always_comb begin
    pct_sat  = (pct > PCT_MAX) ? PCT_MAX : pct;
    prod_nxt = PROD_W'(pct_sat) * PROD_W'(travel);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

  // Floor divide by 4, then by 25 through the reciprocal.
  always_comb begin
    quarter    = prod_r[PROD_W-1:2];
    recip_prod = (2*RECIP25_W)'(quarter) * (2*RECIP25_W)'(RECIP25);
    quot       = 32'(recip_prod >> RECIP25_SHIFT);
  end

  assign target = quot[COUNT_WIDTH-1:0];

endmodule

// ----- src/ehp_ctrl.sv -----
`include "eye_homing_positioner_unit_macros.svh"

// Homing and move sequencer with its counters.
module ehp_ctrl #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  logic                         op,
  input  logic                         sensor_level,
  input  logic [COUNT_WIDTH-1:0]       target,
  input  logic [ehp_pkg::CFG_W-1:0]    home_tmo,
  input  logic [ehp_pkg::HOLD_W-1:0]   sense_hold,
  output logic                         start_load,
  output ehp_pkg::res_t                res
);
  import ehp_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  phase_t                  phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0]  home_cnt_r, home_cnt_nxt;
  logic [HOLD_W-1:0]       hold_cnt_r, hold_cnt_nxt;
  logic [COUNT_WIDTH-1:0]  move_cnt_r, move_cnt_nxt;
  logic [COUNT_WIDTH-1:0]  move_tgt_r, move_tgt_nxt;
  logic [COUNT_WIDTH-1:0]  move_inc;
  logic                    done_nxt;
  logic                    timed_out;
  logic                    home_seen;

  assign start_load = take && (op == OP_START) && (phase_r == PH_IDLE);
  assign timed_out  = CMP_W'(home_cnt_r) >= CMP_W'(home_tmo);
  assign home_seen  = sensor_level && (hold_cnt_r >= sense_hold);
  assign move_inc   = (move_cnt_r == '1) ? move_cnt_r : move_cnt_r + 1'b1;

  // Next state and counters for one accepted transaction.
  always_comb begin
    phase_nxt    = phase_r;
    home_cnt_nxt = home_cnt_r;
    hold_cnt_nxt = hold_cnt_r;
    move_cnt_nxt = move_cnt_r;
    move_tgt_nxt = move_tgt_r;
    done_nxt     = 1'b0;
    if (take) begin
      if (op == OP_START) begin
        if (phase_r == PH_IDLE) begin
          home_cnt_nxt = '0;
          hold_cnt_nxt = '0;
          move_cnt_nxt = '0;
          phase_nxt    = PH_HOMING;
        end
      end else begin
        unique case (phase_r)
          PH_HOMING: begin
            if (timed_out) begin
              phase_nxt = PH_HALTED;
            end else if (home_seen) begin
              home_cnt_nxt = '0;
              move_cnt_nxt = '0;
              move_tgt_nxt = target;
              if (target == '0) begin
                phase_nxt = PH_IDLE;
                done_nxt  = 1'b1;
              end else begin
                phase_nxt = PH_MOVING;
              end
            end else begin
              home_cnt_nxt = (home_cnt_r == '1) ? home_cnt_r : home_cnt_r + 1'b1;
              if (sensor_level) begin
                hold_cnt_nxt = (hold_cnt_r == '1) ? hold_cnt_r : hold_cnt_r + 1'b1;
              end else begin
                hold_cnt_nxt = '0;
              end
            end
          end
          PH_MOVING: begin
            move_cnt_nxt = move_inc;
            if (move_inc >= move_tgt_r) begin
              phase_nxt = PH_IDLE;
              done_nxt  = 1'b1;
            end
          end
          PH_IDLE, PH_HALTED: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result fields reflect the phase after this transaction.
  always_comb begin
    res.drive_right = (phase_nxt == PH_HOMING);
    res.drive_left  = (phase_nxt == PH_MOVING);
    res.busy        = (phase_nxt == PH_HOMING) || (phase_nxt == PH_MOVING);
    res.done        = done_nxt;
    res.halted      = (phase_nxt == PH_HALTED);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      home_cnt_r <= '0;
      hold_cnt_r <= '0;
      move_cnt_r <= '0;
      move_tgt_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      home_cnt_r <= home_cnt_nxt;
      hold_cnt_r <= hold_cnt_nxt;
      move_cnt_r <= move_cnt_nxt;
      move_tgt_r <= move_tgt_nxt;
    end
  end

  // Halt is sticky until reset.
  `EHP_ASSERT_NXT(a_halt_sticky, clk, rst_n, phase_r == PH_HALTED, phase_r == PH_HALTED)
  // A done pulse always leaves the sequencer idle.
  `EHP_ASSERT_NXT(a_done_idle, clk, rst_n, take && res.done, phase_r == PH_IDLE)
  // While moving, the count has not yet reached the target.
  `EHP_ASSERT_IMP(a_move_below, clk, rst_n, phase_r == PH_MOVING, move_cnt_r < move_tgt_r)

endmodule

// ----- src/ehp_out_reg.sv -----
// Result register between the sequencer and the output channel.
module ehp_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  ehp_pkg::res_t  res_in,
  input  logic           out_stall,
  output logic           in_stall,
  output logic           out_valid,
  output ehp_pkg::res_t  res_out
);
  import ehp_pkg::*;

  logic  valid_r, valid_nxt;
  res_t  res_r;

  // A new transaction may enter whenever the held result leaves or none is held.
  assign in_stall  = valid_r && out_stall;
  assign valid_nxt = load ? 1'b1 : (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

// ----- tb/sv/tb_eye_homing_positioner_unit.sv -----
`timescale 1ns / 1ps

module tb_eye_homing_positioner_unit;
  import ehp_pkg::*;

  // Longest receiver hold-off used to back the block up into its input.
  localparam int LONG_HOLD_CYCLES = 300;
  // The slowest legal stretch without any transaction is the long hold-off, plus a
  // long sender gap and a config drain; the limit takes that many times over.
  localparam int WATCHDOG_LIMIT = 5000;
  // Homing ticks of free sensor noise before the stimulus settles the sensor active.
  localparam int HOMING_NOISE_TICKS = 30;
  // A plan row with this repeat count runs until the sequencer is idle again.
  localparam int UNTIL_IDLE = 0;
  localparam int MAX_REPORTS = 200;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  // Result patterns that can be read directly off the sequencer phase.
  localparam res_t RES_IDLE = '{drive_right: 1'b0, drive_left: 1'b0, busy: 1'b0,
                                done: 1'b0, halted: 1'b0};
  localparam res_t RES_HOMING = '{drive_right: 1'b1, drive_left: 1'b0, busy: 1'b1,
                                  done: 1'b0, halted: 1'b0};
  localparam res_t RES_MOVING = '{drive_right: 1'b0, drive_left: 1'b1, busy: 1'b1,
                                  done: 1'b0, halted: 1'b0};
  localparam res_t RES_DONE = '{drive_right: 1'b0, drive_left: 1'b0, busy: 1'b0,
                                done: 1'b1, halted: 1'b0};
  localparam res_t RES_HALTED = '{drive_right: 1'b0, drive_left: 1'b0, busy: 1'b0,
                                  done: 1'b0, halted: 1'b1};

  typedef enum logic {ROW_ITEM, ROW_CFG} plan_kind_t;

  typedef struct {
    plan_kind_t            kind;
    logic                  op;
    logic [PCT_W-1:0]      pct;
    logic                  sens;
    int                    reps;
    bit                    typed;
    res_t                  want;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      wdata;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_op;
  logic [PCT_W-1:0]      in_position_percent;
  logic                  in_sensor_level;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_drive_right;
  logic                  out_drive_left;
  logic                  out_busy_res;
  logic                  out_done_res;
  logic                  out_halted;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;

  // Shadow of the positioner: configuration and sequencer state.
  logic [CFG_W-1:0]      travel_reg;
  logic [CFG_W-1:0]      timeout_reg;
  logic [HOLD_W-1:0]     hold_reg;
  phase_t                pos_phase;
  logic [CFG_W-1:0]      homing_ticks;
  logic [HOLD_W-1:0]     hold_run;
  logic [CFG_W-1:0]      move_ticks;
  logic [CFG_W-1:0]      move_goal;

  res_t                  expected_status_q[$];
  res_t                  status_want;
  plan_row_t             plan_q[$];
  int                    closing_start;
  int                    error_count;
  int                    result_count;
  bit                    calm_mode;
  bit                    hold_off_req;

  eye_homing_positioner_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_position_percent (in_position_percent),
    .in_sensor_level     (in_sensor_level),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_drive_right     (out_drive_right),
    .out_drive_left      (out_drive_left),
    .out_busy_res        (out_busy_res),
    .out_done_res        (out_done_res),
    .out_halted          (out_halted),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Put the shadow back into its reset state.
  function automatic void reset_positioner();
    travel_reg   = LEFT_TRAVEL_RST;
    timeout_reg  = HOME_TMO_RST;
    hold_reg     = SENSE_HOLD_RST;
    pos_phase    = PH_IDLE;
    homing_ticks = '0;
    hold_run     = '0;
    move_ticks   = '0;
    move_goal    = '0;
  endfunction

  // Advance the shadow by one input transaction and return the status it produces.
  function automatic res_t advance_positioner(logic op, logic [PCT_W-1:0] pct, logic sens);
    logic [PCT_W-1:0] pct_sat;
    logic [63:0]      product;
    logic             done;
    res_t             status;
    done = 1'b0;
    if (op == OP_START) begin
      if (pos_phase == PH_IDLE) begin
        pct_sat      = (pct > PCT_MAX) ? PCT_MAX : pct;
        product      = 64'(pct_sat) * 64'(travel_reg);
        move_goal    = CFG_W'(product / 64'(PCT_MAX));
        homing_ticks = '0;
        hold_run     = '0;
        move_ticks   = '0;
        pos_phase    = PH_HOMING;
      end
    end else if (pos_phase == PH_HOMING) begin
      if (homing_ticks >= timeout_reg) begin
        pos_phase = PH_HALTED;
      end else if (sens && hold_run >= hold_reg) begin
        homing_ticks = '0;
        move_ticks   = '0;
        if (move_goal == '0) begin
          pos_phase = PH_IDLE;
          done      = 1'b1;
        end else begin
          pos_phase = PH_MOVING;
        end
      end else begin
        if (homing_ticks != '1) homing_ticks = homing_ticks + 1'b1;
        if (!sens) begin
          hold_run = '0;
        end else if (hold_run != '1) begin
          hold_run = hold_run + 1'b1;
        end
      end
    end else if (pos_phase == PH_MOVING) begin
      if (move_ticks != '1) move_ticks = move_ticks + 1'b1;
      if (move_ticks >= move_goal) begin
        pos_phase = PH_IDLE;
        done      = 1'b1;
      end
    end
    status.drive_right = (pos_phase == PH_HOMING);
    status.drive_left  = (pos_phase == PH_MOVING);
    status.busy        = (pos_phase == PH_HOMING) || (pos_phase == PH_MOVING);
    status.done        = done;
    status.halted      = (pos_phase == PH_HALTED);
    return status;
  endfunction

  // Sender gap: mostly none, sometimes short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_mode || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random transaction shaped by the sequencer phase. While homing, the sensor is kept active
  // after the noise ticks, or once noise could run the homing timer out.
  function automatic void pick_random_item(output logic op, output logic [PCT_W-1:0] pct,
                                           output logic sens);
    int r;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 85) begin
      pct = PCT_W'($urandom_range(0, 127));
    end else begin
      case ($urandom_range(0, 3))
        0:       pct = '0;
        1:       pct = PCT_MAX;
        2:       pct = PCT_MAX + 1'b1;
        default: pct = '1;
      endcase
    end
    sens = 1'($urandom_range(0, 1));
    case (pos_phase)
      PH_IDLE: begin
        op = (r < 75) ? OP_START : OP_TICK;
      end
      PH_HOMING: begin
        op = (r < 6) ? OP_START : OP_TICK;
        if (int'(homing_ticks) > HOMING_NOISE_TICKS ||
            int'(homing_ticks) + 1 + int'(hold_reg) >= int'(timeout_reg)) begin
          sens = 1'b1;
        end else begin
          sens = ($urandom_range(0, 99) < 80);
        end
      end
      PH_MOVING: begin
        op = (r < 6) ? OP_START : OP_TICK;
      end
      default: begin
        op = 1'($urandom_range(0, 1));
      end
    endcase
  endfunction

  task automatic report_mismatch(string what);
    if (error_count < MAX_REPORTS) $display("ERROR: %s at %0t", what, $realtime);
    error_count++;
  endtask

  task automatic check_field(string name, logic got, logic want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d field %s got %b expected %b",
                                result_count, name, got, want));
    end
  endtask

  // Offer one transaction and hold it until the block accepts it.
  task automatic send_item(logic op, logic [PCT_W-1:0] pct, logic sens);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_op               <= op;
    in_position_percent <= pct;
    in_sensor_level     <= sens;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Register write once every outstanding result has arrived.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_status_q.size() != 0);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_IDX_LEFT_TRAVEL: travel_reg  = data;
      CFG_IDX_HOME_TMO:    timeout_reg = data;
      CFG_IDX_SENSE_HOLD:  hold_reg    = data[HOLD_W-1:0];
      default: ;
    endcase
  endtask

  function automatic void add_item(logic op, logic [PCT_W-1:0] pct, logic sens, int reps,
                                   bit typed, res_t want);
    plan_row_t row;
    row.kind  = ROW_ITEM;
    row.op    = op;
    row.pct   = pct;
    row.sens  = sens;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    row.idx   = '0;
    row.wdata = '0;
    plan_q.push_back(row);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    plan_row_t row;
    row.kind  = ROW_CFG;
    row.op    = OP_TICK;
    row.pct   = '0;
    row.sens  = 1'b0;
    row.reps  = 1;
    row.typed = 1'b0;
    row.want  = RES_IDLE;
    row.idx   = idx;
    row.wdata = data;
    plan_q.push_back(row);
  endfunction

  // Directed plan. The halting rows sit at the end, since only reset clears a halt.
  function automatic void build_plan();
    // Ticks while idle, then a homing run against the reset hold and travel.
    add_item(OP_TICK, 7'd0, 1'b0, 1, 1'b1, RES_IDLE);
    add_item(OP_TICK, '1, 1'b1, 1, 1'b1, RES_IDLE);
    add_item(OP_START, 7'd1, 1'b0, 1, 1'b1, RES_HOMING);
    add_item(OP_START, 7'd90, 1'b1, 1, 1'b1, RES_HOMING);
    add_item(OP_TICK, 7'd0, 1'b0, 3, 1'b1, RES_HOMING);
    add_item(OP_TICK, 7'd0, 1'b1, 200, 1'b1, RES_HOMING);
    add_item(OP_TICK, 7'd0, 1'b1, 1, 1'b1, RES_MOVING);
    add_item(OP_START, 7'd50, 1'b0, 1, 1'b1, RES_MOVING);
    add_item(OP_TICK, 7'd0, 1'b0, UNTIL_IDLE, 1'b0, RES_IDLE);
    add_item(OP_TICK, 7'd0, 1'b1, 1, 1'b1, RES_IDLE);
    // An index with no register behind it changes nothing.
    add_cfg(CFG_IDX_UNUSED, '1);
    // Percent above full scale saturates, and a zero target finishes at home.
    add_cfg(CFG_IDX_LEFT_TRAVEL, 24'd10);
    add_cfg(CFG_IDX_SENSE_HOLD, 24'd0);
    add_item(OP_START, '1, 1'b0, 1, 1'b1, RES_HOMING);
    add_item(OP_TICK, 7'd0, 1'b1, 1, 1'b1, RES_MOVING);
    add_item(OP_TICK, 7'd0, 1'b1, UNTIL_IDLE, 1'b0, RES_IDLE);
    add_item(OP_START, 7'd0, 1'b0, 1, 1'b1, RES_HOMING);
    add_item(OP_TICK, 7'd0, 1'b1, 1, 1'b1, RES_DONE);
    // A travel that truncates on the divide, with the upper data bits set on the hold write.
    add_cfg(CFG_IDX_LEFT_TRAVEL, 24'd199);
    add_cfg(CFG_IDX_SENSE_HOLD, 24'hFFFF00);
    add_item(OP_START, 7'd1, 1'b0, 1, 1'b1, RES_HOMING);
    add_item(OP_TICK, 7'd0, 1'b1, 1, 1'b1, RES_MOVING);
    add_item(OP_TICK, 7'd0, 1'b0, UNTIL_IDLE, 1'b0, RES_IDLE);
    closing_start = plan_q.size();
    // A zero timeout halts on the first homing tick; the halt is sticky.
    add_cfg(CFG_IDX_HOME_TMO, 24'd0);
    add_item(OP_START, 7'd50, 1'b1, 1, 1'b1, RES_HOMING);
    add_item(OP_TICK, 7'd0, 1'b1, 1, 1'b1, RES_HALTED);
    add_item(OP_START, PCT_MAX, 1'b0, 1, 1'b1, RES_HALTED);
    add_item(OP_TICK, 7'd0, 1'b0, 1, 1'b1, RES_HALTED);
    add_item(OP_TICK, '1, 1'b1, 1, 1'b1, RES_HALTED);
  endfunction

  task automatic run_rows(int first, int last);
    plan_row_t row;
    res_t      predicted;
    int        n;
    for (int i = first; i <= last; i++) begin
      row = plan_q[i];
      if (row.kind == ROW_CFG) begin
        cfg_write(row.idx, row.wdata);
      end else begin
        n = 0;
        do begin
          predicted = advance_positioner(row.op, row.pct, row.sens);
          expected_status_q.push_back(row.typed ? row.want : predicted);
          send_item(row.op, row.pct, row.sens);
          n++;
        end while ((row.reps == UNTIL_IDLE) ? (pos_phase != PH_IDLE) : (n < row.reps));
      end
    end
  endtask

  // Random transactions; a positioning run in progress is always carried to its end.
  task automatic run_random_phase(int budget);
    logic             op;
    logic [PCT_W-1:0] pct;
    logic             sens;
    res_t             predicted;
    int               n;
    n = 0;
    while (n < budget || pos_phase == PH_HOMING || pos_phase == PH_MOVING) begin
      pick_random_item(op, pct, sens);
      predicted = advance_positioner(op, pct, sens);
      expected_status_q.push_back(predicted);
      send_item(op, pct, sens);
      n++;
    end
  endtask

  // Result sink: random stall stretches, calm stretches and one long hold-off.
  initial begin : result_sink
    int   span;
    logic stall_next;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_next   = 1'b1;
        span         = LONG_HOLD_CYCLES;
      end else if (calm_mode) begin
        stall_next = 1'b0;
        span       = 1;
      end else begin
        stall_next = ($urandom_range(0, 99) < 30);
        span = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      end
      out_stall <= stall_next;
      repeat (span) @(posedge clk);
    end
  end

  // Compare every accepted result transaction with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (expected_status_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", result_count));
      end else begin
        status_want = expected_status_q.pop_front();
        check_field("drive_right", out_drive_right, status_want.drive_right);
        check_field("drive_left", out_drive_left, status_want.drive_left);
        check_field("busy_res", out_busy_res, status_want.busy);
        check_field("done_res", out_done_res, status_want.done);
        check_field("halted", out_halted, status_want.halted);
      end
    end
  end

  // Watchdog: ends the run when no transaction of any kind happens for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("FAIL eye_homing_positioner_unit");
    $finish;
  end

  // Main sequence: reset, directed plan, random phases, halting rows, a last random phase, drain.
  initial begin : main_seq
    logic [CFG_W-1:0]  travel_v;
    logic [CFG_W-1:0]  tmo_v;
    logic [HOLD_W-1:0] hold_v;
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_op               = OP_TICK;
    in_position_percent = '0;
    in_sensor_level     = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    error_count         = 0;
    result_count        = 0;
    calm_mode           = 1'b0;
    hold_off_req        = 1'b0;
    reset_positioner();
    build_plan();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    run_rows(0, closing_start - 1);

    for (int k = 0; k < 7; k++) begin
      case (k)
        0: begin
          travel_v = '0;
          tmo_v    = '1;
          hold_v   = '0;
        end
        1: begin
          travel_v = CFG_W'($urandom_range(1, 60));
          tmo_v    = 24'd1;
          hold_v   = '0;
        end
        2: begin
          travel_v = CFG_W'($urandom_range(1, 40));
          tmo_v    = CFG_W'($urandom_range(300, 24'hFFFFFF));
          hold_v   = '1;
        end
        default: begin
          travel_v = CFG_W'($urandom_range(1, 60));
          tmo_v    = ($urandom_range(0, 9) < 3) ? '1 : CFG_W'($urandom_range(300, 24'hFFFFFF));
          hold_v   = HOLD_W'($urandom_range(0, 12));
        end
      endcase
      cfg_write(CFG_IDX_LEFT_TRAVEL, travel_v);
      cfg_write(CFG_IDX_HOME_TMO, tmo_v);
      cfg_write(CFG_IDX_SENSE_HOLD, {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                     hold_v});
      calm_mode    = (k == 4) || ($urandom_range(0, 4) == 0);
      hold_off_req = (k == 3);
      // The hold-off phase runs longer so the sender is still offering when it starts.
      run_random_phase((k == 3) ? 100 : 30);
    end

    calm_mode = 1'b0;
    run_rows(closing_start, plan_q.size() - 1);
    run_random_phase(16);

    // Let every outstanding result arrive, then keep watching for stray results.
    in_valid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0 && expected_status_q.size() == 0) begin
      $display("PASS eye_homing_positioner_unit");
    end else begin
      $display("FAIL eye_homing_positioner_unit");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/ehp_pkg.sv
src/ehp_target.sv
src/ehp_ctrl.sv
src/ehp_out_reg.sv
src/eye_homing_positioner_unit.sv
tb/sv/tb_eye_homing_positioner_unit.sv
